// ----- rtl/core/srd_pkg.sv -----
// srd_pkg: shared types, codes and constants of the sorted rank decoder
// depends on nothing; used by every module in rtl/core
package srd_pkg;

   localparam int HDR_BYTES     = 1024;
   localparam int NUM_SYM       = 256;
   localparam int DEF_MAX_BLOCK = 65536;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] STAT_BYTE = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN,
      ST_ASG_RD,
      ST_ASG_WR,
      ST_D_BKT,
      ST_D_MOVE
   } state_type;

   typedef enum logic {
      PH_LOAD,
      PH_DEC
   } phase_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       block_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic       clear;
      logic       ins;
      logic [7:0] lim;
      logic [7:0] pos;
      logic [7:0] value;
   } rank_ctl_type;

   typedef struct packed {
      logic       clear;
      logic       insert;
      logic       pop;
      logic [7:0] sym;
   } sort_ctl_type;

endpackage

// ----- rtl/core/srd_rank_cell.sv -----
// srd_rank_cell: one entry of the rank list, shifts toward the front
// depends on srd_pkg
module srd_rank_cell
   import srd_pkg::*;
(
   input  logic         clock,
   input  rank_ctl_type ctl,
   input  logic [7:0]   cell_idx,
   input  logic [7:0]   right_sym,
   output logic [7:0]   sym
);

   logic [7:0] sym_ff;
   logic [7:0] sym_in;

   always_comb begin
      sym_in = sym_ff;
      if (ctl.clear) begin
         sym_in = 8'd0;
      end else if (cell_idx < ctl.lim) begin
         sym_in = right_sym;
      end else if (ctl.ins && (cell_idx == ctl.pos)) begin
         sym_in = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

   assign sym = sym_ff;

endmodule

// ----- rtl/core/srd_sort_cell.sv -----
// srd_sort_cell: one slot of the insertion sorter, count descending, ties to smaller symbol
// depends on srd_pkg
module srd_sort_cell
   import srd_pkg::*;
#(
   parameter int CNT_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  sort_ctl_type     ctl,
   input  logic [CNT_W-1:0] new_cnt,
   input  logic             left_ahead,
   input  logic             left_valid,
   input  logic [CNT_W-1:0] left_cnt,
   input  logic [7:0]       left_sym,
   input  logic             right_valid,
   input  logic [CNT_W-1:0] right_cnt,
   input  logic [7:0]       right_sym,
   output logic             ahead,
   output logic             valid,
   output logic [CNT_W-1:0] cnt,
   output logic [7:0]       sym
);

   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       sym_ff, sym_in;

   // symbols arrive in increasing order, so an equal count stays behind
   assign ahead = !valid_ff || (new_cnt > cnt_ff);

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      sym_in   = sym_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         valid_in = right_valid;
         cnt_in   = right_cnt;
         sym_in   = right_sym;
      end else if (ctl.insert) begin
         if (left_ahead) begin
            valid_in = left_valid;
            cnt_in   = left_cnt;
            sym_in   = left_sym;
         end else if (ahead) begin
            valid_in = 1'b1;
            cnt_in   = new_cnt;
            sym_in   = ctl.sym;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      sym_ff <= sym_in;
   end

   assign valid = valid_ff;
   assign cnt   = cnt_ff;
   assign sym   = sym_ff;

endmodule

// ----- rtl/core/sorted_rank_decoder_core.sv -----
// sorted_rank_decoder_core: top level, block load, header sort, bucket setup, byte decode
// depends on srd_pkg, srd_sort_cell, srd_rank_cell
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_data  (req_word_type)
//  rsp      out        rsp_valid/rsp_ready   rsp_data  (rsp_word_type)
//
// a load word is taken in idle; a drain word that gives a byte then runs a bucket
// memory read, a rank store read and a rank list shift, or ends after the bucket
// memory read when its bucket is exhausted; other drains are answered in idle
// the word with block_end is followed by ST_FIN and, for a well-formed block, one
// ST_ASG_RD/ST_ASG_WR pair per present symbol; each rank store read seeds the rank list
// reset is synchronous and clears control state only; the stores need no clearing
// req_ready is low outside idle; a drain is also held off while an untaken result
// sits in the output register
module sorted_rank_decoder_core
   import srd_pkg::*;
#(
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam int PW = $clog2(MAX_BLOCK + HDR_BYTES + 1);
   localparam int AW = $clog2(MAX_BLOCK);
   localparam int SW = CW + 8;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [23:0]  gather_ff, gather_in;
   logic         mal_ff, mal_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [8:0]   live_ff, live_in;
   logic [CW-1:0] apos_ff, apos_in;
   logic [7:0]   asym_ff, asym_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   logic [7:0]    rank_mem [MAX_BLOCK];
   logic [CW-1:0] bn_mem   [NUM_SYM];
   logic [CW-1:0] bl_mem   [NUM_SYM];
   logic [7:0]    rank_rd_ff;
   logic [CW-1:0] bn_rd_ff, bl_rd_ff;

   logic          rank_we;
   logic [AW-1:0] rank_wa, rank_ra;
   logic          bn_we, bl_we;
   logic [7:0]    bkt_wa;
   logic [CW-1:0] bn_wd, bl_wd;

   logic          load_acc, drain_acc, new_blk, short_hdr, bad_blk;
   logic [PW-1:0] pos_eff, data_off;
   logic [23:0]   gather_eff;
   logic          mal_eff;
   logic [SW-1:0] sum_eff;
   logic [31:0]   full_word;
   logic [CW-1:0] cnt_new, dlen;

   rank_ctl_type  rank_ctl;
   sort_ctl_type  sort_ctl;

   logic [7:0]    rank_sym [NUM_SYM+1];
   logic          sort_v   [NUM_SYM+2];
   logic [CW-1:0] sort_c   [NUM_SYM+2];
   logic [7:0]    sort_s   [NUM_SYM+2];
   logic          sort_b   [NUM_SYM+1];

   // ---------------- cell chains ----------------
   assign rank_sym[NUM_SYM] = 8'd0;
   assign sort_v[0] = 1'b0;
   assign sort_c[0] = '0;
   assign sort_s[0] = 8'd0;
   assign sort_b[0] = 1'b0;
   assign sort_v[NUM_SYM+1] = 1'b0;
   assign sort_c[NUM_SYM+1] = '0;
   assign sort_s[NUM_SYM+1] = 8'd0;

   for (genvar g = 0; g < NUM_SYM; g++) begin : g_cells
      srd_rank_cell u_rank (
         .clock     (clock),
         .ctl       (rank_ctl),
         .cell_idx  (8'(g)),
         .right_sym (rank_sym[g+1]),
         .sym       (rank_sym[g])
      );
      srd_sort_cell #(.CNT_W(CW)) u_sort (
         .clock       (clock),
         .reset       (reset),
         .ctl         (sort_ctl),
         .new_cnt     (cnt_new),
         .left_ahead  (sort_b[g]),
         .left_valid  (sort_v[g]),
         .left_cnt    (sort_c[g]),
         .left_sym    (sort_s[g]),
         .right_valid (sort_v[g+2]),
         .right_cnt   (sort_c[g+2]),
         .right_sym   (sort_s[g+2]),
         .ahead       (sort_b[g+1]),
         .valid       (sort_v[g+1]),
         .cnt         (sort_c[g+1]),
         .sym         (sort_s[g+1])
      );
   end

   // ---------------- handshake ----------------
   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_data.opcode == OP_LOAD) || !rsp_valid_ff || rsp_ready);
   assign load_acc  = req_valid && req_ready && (req_data.opcode == OP_LOAD);
   assign drain_acc = req_valid && req_ready && (req_data.opcode == OP_DRAIN);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_acc && req_data.block_end) begin
               state_in = ST_FIN;
            end else if (drain_acc && (phase_ff == PH_DEC) && !mal_ff &&
                         (emit_ff < len_ff)) begin
               state_in = ST_D_BKT;
            end
         end
         ST_FIN: begin
            state_in = (!bad_blk && sort_v[1]) ? ST_ASG_RD : ST_IDLE;
         end
         ST_ASG_RD: state_in = ST_ASG_WR;
         ST_ASG_WR: state_in = sort_v[1] ? ST_ASG_RD : ST_IDLE;
         ST_D_BKT: state_in = (bn_rd_ff < bl_rd_ff) ? ST_D_MOVE : ST_IDLE;
         ST_D_MOVE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and controls ----------------
   assign new_blk    = (phase_ff == PH_DEC);
   assign pos_eff    = new_blk ? '0 : pos_ff;
   assign gather_eff = new_blk ? 24'd0 : gather_ff;
   assign mal_eff    = new_blk ? 1'b0 : mal_ff;
   assign sum_eff    = new_blk ? '0 : sum_ff;
   assign data_off   = pos_eff - PW'(HDR_BYTES);
   assign full_word  = {gather_eff, req_data.data_byte};
   assign cnt_new    = (full_word > 32'(MAX_BLOCK)) ? CW'(MAX_BLOCK) : full_word[CW-1:0];
   assign short_hdr  = pos_ff < PW'(HDR_BYTES);
   assign dlen       = short_hdr ? '0 : CW'(pos_ff - PW'(HDR_BYTES));
   assign bad_blk    = mal_ff || short_hdr || (sum_ff != SW'(dlen));

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      gather_in    = gather_ff;
      mal_in       = mal_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      emit_in      = emit_ff;
      live_in      = live_ff;
      apos_in      = apos_ff;
      asym_in      = asym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rank_we      = 1'b0;
      rank_wa      = data_off[AW-1:0];
      rank_ra      = bn_rd_ff[AW-1:0];
      bn_we        = 1'b0;
      bl_we        = 1'b0;
      bkt_wa       = rank_sym[0];
      bn_wd        = bn_rd_ff + CW'(1);
      bl_wd        = apos_ff + sort_c[1];
      rank_ctl     = '0;
      sort_ctl     = '0;
      sort_ctl.sym = pos_eff[9:2];

      case (state_ff)
         ST_IDLE: begin
            if (load_acc) begin
               phase_in       = PH_LOAD;
               pos_in         = pos_eff;
               gather_in      = gather_eff;
               mal_in         = mal_eff;
               sum_in         = sum_eff;
               sort_ctl.clear = new_blk;
               if (pos_eff < PW'(HDR_BYTES)) begin
                  pos_in = pos_eff + PW'(1);
                  if (pos_eff[1:0] != 2'd3) begin
                     gather_in = {gather_eff[15:0], req_data.data_byte};
                  end else begin
                     gather_in = 24'd0;
                     sum_in    = sum_eff + SW'(cnt_new);
                     if (full_word > 32'(MAX_BLOCK)) begin
                        mal_in = 1'b1;
                     end
                     sort_ctl.insert = (cnt_new != '0);
                  end
               end else if (data_off < PW'(MAX_BLOCK)) begin
                  rank_we = 1'b1;
                  pos_in  = pos_eff + PW'(1);
               end else begin
                  mal_in = 1'b1;
               end
            end else if (drain_acc) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (phase_ff != PH_DEC) begin
                  rsp_in.status = STAT_NONE;
               end else if (mal_ff) begin
                  rsp_in.status = STAT_BAD;
               end else if (emit_ff >= len_ff) begin
                  rsp_in.status = STAT_NONE;
               end else begin
                  rsp_in.out_byte = rank_sym[0] & BYTE_MASK;
                  rsp_in.out_last = (emit_ff + CW'(1)) == len_ff;
                  rsp_in.status   = STAT_BYTE;
                  emit_in         = emit_ff + CW'(1);
               end
            end
         end
         ST_FIN: begin
            phase_in       = PH_DEC;
            mal_in         = bad_blk;
            len_in         = dlen;
            emit_in        = '0;
            live_in        = 9'd0;
            apos_in        = '0;
            rank_ctl.clear = 1'b1;
         end
         ST_ASG_RD: begin
            rank_ra      = apos_ff[AW-1:0];
            bkt_wa       = sort_s[1];
            bn_we        = 1'b1;
            bn_wd        = apos_ff + CW'(1);
            bl_we        = 1'b1;
            apos_in      = apos_ff + sort_c[1];
            asym_in      = sort_s[1];
            live_in      = live_ff + 9'd1;
            sort_ctl.pop = 1'b1;
         end
         ST_ASG_WR: begin
            // seed the rank list with the first rank of this bucket
            rank_ctl.ins   = 1'b1;
            rank_ctl.pos   = rank_rd_ff;
            rank_ctl.value = asym_ff;
         end
         ST_D_BKT: begin
            if (bn_rd_ff < bl_rd_ff) begin
               bn_we = 1'b1;
            end else if (live_ff > 9'd1) begin
               // bucket exhausted: front symbol leaves the list
               live_in      = live_ff - 9'd1;
               rank_ctl.lim = 8'(live_ff - 9'd1);
            end
         end
         ST_D_MOVE: begin
            if (rank_rd_ff != 8'd0) begin
               rank_ctl.lim   = rank_rd_ff;
               rank_ctl.ins   = 1'b1;
               rank_ctl.pos   = rank_rd_ff;
               rank_ctl.value = rank_sym[0];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- stores ----------------
   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_wa] <= req_data.data_byte;
      end
      rank_rd_ff <= rank_mem[rank_ra];
   end

   always_ff @(posedge clock) begin
      if (bn_we) begin
         bn_mem[bkt_wa] <= bn_wd;
      end
      if (bl_we) begin
         bl_mem[bkt_wa] <= bl_wd;
      end
      bn_rd_ff <= bn_mem[rank_sym[0]];
      bl_rd_ff <= bl_mem[rank_sym[0]];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOAD;
         pos_ff       <= '0;
         gather_ff    <= 24'd0;
         mal_ff       <= 1'b0;
         sum_ff       <= '0;
         len_ff       <= '0;
         emit_ff      <= '0;
         live_ff      <= 9'd0;
         apos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         gather_ff    <= gather_in;
         mal_ff       <= mal_in;
         sum_ff       <= sum_in;
         len_ff       <= len_in;
         emit_ff      <= emit_in;
         live_ff      <= live_in;
         apos_ff      <= apos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      asym_ff <= asym_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");

   a_live_range: assert property (@(posedge clock) disable iff (reset)
      live_ff <= 9'd256)
      else $error("live symbol count out of range");

   a_emit_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEC) |-> (emit_ff <= len_ff))
      else $error("emitted more bytes than the block holds");

   a_drain_rsp: assert property (@(posedge clock) disable iff (reset)
      drain_acc |=> rsp_valid_ff)
      else $error("drain word gave no result");
`endif

endmodule

// ----- tb/srd_checker.sv -----
// srd_checker: watches the req and rsp channels of the sorted rank decoder,
// predicts each drain answer and compares it; depends on srd_pkg
`timescale 1ns / 100ps
module srd_checker
   import srd_pkg::*;
#(
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   output int           errors,
   output int           pending
);

   localparam int unsigned MAXB = MAX_BLOCK;

   int unsigned   load_pos, gather, data_len, emitted, live;
   int unsigned   sym_count [NUM_SYM];
   int unsigned   bkt_next [NUM_SYM];
   int unsigned   bkt_limit [NUM_SYM];
   logic [7:0]    sorted_syms [NUM_SYM];
   logic [7:0]    rank_list [NUM_SYM];
   logic [7:0]    rank_mem [MAXB];
   logic [7:0]    cur_sym;
   phase_type     dec_phase;
   bit            bad_block;
   rsp_word_type  expected_words [$];

   assign pending = expected_words.size();

   initial errors = 0;

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic bit ranks_first(int unsigned a, int unsigned b);
      if (sym_count[a] != sym_count[b]) return sym_count[a] > sym_count[b];
      return a < b;
   endfunction

   function automatic void close_block();
      longint unsigned sum;
      int unsigned n, j, pos;
      logic [7:0] c;
      sum = 0;
      n = 0;
      dec_phase = PH_DEC;
      emitted = 0;
      cur_sym = 0;
      live = 0;
      foreach (rank_list[i]) rank_list[i] = 0;
      if (load_pos < HDR_BYTES) begin
         bad_block = 1;
         data_len = 0;
         return;
      end
      data_len = load_pos - HDR_BYTES;
      for (int unsigned i = 0; i < NUM_SYM; i++) begin
         sum += sym_count[i];
         if (sym_count[i] != 0) begin
            j = n;
            while (j > 0 && ranks_first(i, sorted_syms[j-1])) begin
               sorted_syms[j] = sorted_syms[j-1];
               j--;
            end
            sorted_syms[j] = i[7:0];
            n++;
         end
      end
      if (sum != data_len) bad_block = 1;
      if (bad_block) return;
      pos = 0;
      for (int unsigned i = 0; i < n; i++) begin
         c = sorted_syms[i];
         rank_list[rank_mem[pos % MAXB]] = c;
         bkt_next[c] = pos + 1;
         pos += sym_count[c];
         bkt_limit[c] = pos;
      end
      live = n;
      cur_sym = rank_list[0];
   endfunction

   function automatic void take_byte(logic [7:0] b, logic last);
      int unsigned full;
      if (dec_phase != PH_LOAD) begin
         dec_phase = PH_LOAD;
         load_pos = 0;
         gather = 0;
         bad_block = 0;
      end
      if (load_pos < HDR_BYTES) begin
         if ((load_pos & 3) < 3) begin
            gather = ((gather << 8) | b) & 32'hFFFFFF;
         end else begin
            full = (gather << 8) | b;
            if (full > MAXB) begin
               bad_block = 1;
               full = MAXB;
            end
            sym_count[(load_pos >> 2) & 8'hFF] = full;
            gather = 0;
         end
         load_pos++;
      end else if (load_pos - HDR_BYTES < MAXB) begin
         rank_mem[load_pos - HDR_BYTES] = b;
         load_pos++;
      end else begin
         bad_block = 1;
      end
      if (last) close_block();
   endfunction

   // move to the next symbol after one decoded byte
   function automatic void step_symbol();
      logic [7:0] c;
      int unsigned r;
      c = cur_sym;
      if (bkt_next[c] < bkt_limit[c]) begin
         r = rank_mem[bkt_next[c] % MAXB];
         bkt_next[c]++;
         if (r == 0) return;
         for (int unsigned k = 0; k < r; k++) rank_list[k] = rank_list[k+1];
         rank_list[r] = c;
         cur_sym = rank_list[0];
      end else begin
         if (live <= 1) return;
         live--;
         for (int unsigned k = 0; k < live; k++) rank_list[k] = rank_list[k+1];
         cur_sym = rank_list[0];
      end
   endfunction

   function automatic rsp_word_type drain_answer();
      rsp_word_type w;
      w = '0;
      if (dec_phase != PH_DEC) begin
         w.status = STAT_NONE;
      end else if (bad_block) begin
         w.status = STAT_BAD;
      end else if (emitted >= data_len) begin
         w.status = STAT_NONE;
      end else begin
         w.out_byte = cur_sym;
         w.out_last = (emitted + 1 == data_len);
         w.status = STAT_BYTE;
         emitted++;
         step_symbol();
      end
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         load_pos = 0;
         gather = 0;
         cur_sym = 0;
         live = 0;
         emitted = 0;
         data_len = 0;
         dec_phase = PH_LOAD;
         bad_block = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_data, 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.out_byte != want.out_byte)
                  report("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.out_last != want.out_last)
                  report("out_last", rsp_data.out_last, want.out_last);
               if (rsp_data.status != want.status)
                  report("status", rsp_data.status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_LOAD)
               take_byte(req_data.data_byte, req_data.block_end);
            else
               expected_words.push_back(drain_answer());
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for sorted_rank_decoder_core
// depends on srd_pkg, the core and srd_checker
`timescale 1ns / 100ps
module tb_top;
   import srd_pkg::*;

   localparam int LIMIT = 3000000;
   // smallest store keeps the overflow case short
   localparam int BLK = 256;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_word_type rsp_data;
   int           errors, pending;
   int           snd_idle, rcv_idle;
   int unsigned  cycles = 0;
   logic [31:0]  hdr [NUM_SYM];

   sorted_rank_decoder_core #(.MAX_BLOCK(BLK)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   srd_checker #(.MAX_BLOCK(BLK)) chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   // one word, held until the core takes it
   task automatic send(logic op, logic [7:0] b, logic last);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{opcode: op, data_byte: b, block_end: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drains(int n);
      repeat (n) send(OP_DRAIN, 8'($urandom), 1'($urandom));
   endtask

   // header from hdr, then len rank bytes; nhdr < 1024 cuts the header short
   task automatic load_block(int nhdr, int len, int rmax);
      logic [7:0] b;
      for (int i = 0; i < nhdr; i++) begin
         if ($urandom_range(199) == 0) send(OP_DRAIN, 8'($urandom), 1'($urandom));
         b = 8'(hdr[i/4] >> (8 * (3 - i % 4)));
         send(OP_LOAD, b, (len == 0 || nhdr < HDR_BYTES) && i == nhdr - 1);
      end
      if (nhdr < HDR_BYTES) return;
      for (int i = 0; i < len; i++) begin
         b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(rmax));
         send(OP_LOAD, b, i == len - 1);
      end
   endtask

   task automatic clear_hdr();
      foreach (hdr[i]) hdr[i] = 0;
   endtask

   task automatic directed();
      drains(1);
      // empty block is well formed and gives nothing
      clear_hdr();
      load_block(HDR_BYTES, 0, 0);
      drains(2);
      // ties go to the smaller symbol
      clear_hdr();
      hdr[0] = 2; hdr[255] = 2; hdr[7] = 1;
      load_block(HDR_BYTES, 5, 3);
      drains(6);
      // oversized counts
      clear_hdr();
      hdr[0] = 32'h0001_0001; hdr[5] = 32'hFFFF_FFFF;
      load_block(HDR_BYTES, 3, 3);
      drains(2);
      // counts do not add up
      clear_hdr();
      hdr[0] = 3;
      load_block(HDR_BYTES, 2, 3);
      drains(2);
      // header cut short
      load_block(10, 0, 0);
      drains(2);
      // ranks beyond the live symbols
      clear_hdr();
      hdr[0] = 2; hdr[1] = 2;
      load_block(HDR_BYTES, 4, 255);
      drains(5);
   endtask

   task automatic random_block();
      int len, nsel, kind;
      logic [7:0] syms [6];
      clear_hdr();
      len = $urandom_range(1, 40);
      nsel = $urandom_range(1, 6);
      syms[0] = 0;
      for (int i = 1; i < 6; i++) syms[i] = 8'($urandom);
      // symbol 0 always present so decoding never touches an unused bucket
      hdr[0] = 1;
      for (int i = 1; i < len; i++) hdr[syms[$urandom_range(nsel - 1)]]++;
      kind = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
      if (kind == 1) hdr[$urandom_range(255)]++;
      if (kind == 2) hdr[$urandom_range(255)] = ($urandom_range(3) != 0) ? $urandom : 32'h10001;
      load_block(kind == 3 ? $urandom_range(1, HDR_BYTES - 1) : HDR_BYTES, len, nsel + 1);
      drains(len + $urandom_range(0, 3));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int ph = 0; ph < 3; ph++) begin
         snd_idle = (ph == 0) ? 14 : (ph == 1) ? 73 : 0;
         rcv_idle = (ph == 0) ? 73 : (ph == 1) ? 14 : 0;
         if (ph == 0) directed();
         repeat (2) random_block();
      end
      // more rank bytes than the store holds
      clear_hdr();
      hdr[0] = BLK;
      load_block(HDR_BYTES, BLK + 1, 255);
      drains(3);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
